// ===== hw/rtl/rsm_pkg.sv =====
package rsm_pkg;

    localparam int NODES      = 1024;
    localparam int NODE_W     = $clog2(NODES);
    localparam int STUB_W     = 10;
    localparam int TOTAL_W    = 20;
    localparam int REJ_W      = 9;
    localparam int PREFIX_W   = STUB_W + NODE_W;
    localparam int RAND_W     = 16;
    localparam int STATUS_W   = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
    localparam logic [STUB_W-1:0]  STUB_MAX   = {STUB_W{1'b1}};
    localparam logic [REJ_W-1:0]   REJ_MAX    = {REJ_W{1'b1}};
    localparam logic [TOTAL_W-1:0] STOP_TOTAL = TOTAL_W'(3);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    localparam logic REG_BT_EN  = 1'b0;
    localparam logic REG_MAX_BT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_EDGE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINISH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 2'd3;

    typedef struct packed {
        logic [TOTAL_W-1:0]  stubs_left;
        logic [9:0]          end_b;
        logic [9:0]          end_a;
        logic [STATUS_W-1:0] status;
    } result_t;

    // which parts of a stub take actually happened
    typedef struct packed {
        logic tot;
        logic mat;
        logic rem;
    } take_t;

endpackage

// ===== hw/rtl/rsm_out_stage.sv =====
module rsm_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  rsm_pkg::result_t push_data,
    output logic            push_ready,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [39:0]     m_axis_tdata,   // end_a, end_b, stubs_left
    output logic [1:0]      m_axis_tuser    // status
);

    logic             full_reg;
    rsm_pkg::result_t data_reg;

    assign push_ready    = !full_reg || m_axis_tready;
    assign m_axis_tvalid = full_reg;
    assign m_axis_tdata  = {data_reg.stubs_left, data_reg.end_b, data_reg.end_a};
    assign m_axis_tuser  = data_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            full_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

endmodule

// ===== hw/rtl/random_stub_matching_unit.sv =====
// load: read in S_LD_RD, write in S_LD_WR, then S_DONE; stop check: straight to S_DONE.
// match step: two scans of the stub memory, one node per cycle through
// the single read port of the stub memory.
// one item at a time; the result waits in an output register.
// after reset a clearing pass over all NODES addresses zeroes the stub and adjacency
// memories; no word is accepted until it ends. registers reset to 1 and 80.
module random_stub_matching_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // node, stubs, rand_first, rand_second
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // end_a, end_b, stubs_left
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int NW = rsm_pkg::NODE_W;
    localparam int SW = rsm_pkg::STUB_W;
    localparam int TW = rsm_pkg::TOTAL_W;
    localparam int PW = rsm_pkg::PREFIX_W;
    localparam int RW = rsm_pkg::RAND_W;
    localparam int N  = rsm_pkg::NODES;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_MUL, S_SCAN, S_TK_RD, S_TK_WR,
        S_ADJ_RD, S_ADJ_CHK, S_ADJ_RD2, S_ADJ_WR2, S_GB_RD, S_GB_WR, S_DONE
    } state_t;

    // memories: {remaining, matched} per node, adjacency row per node
    logic [2*SW-1:0] stub_mem [N];
    logic [N-1:0]    adj_mem  [N];
    logic [2*SW-1:0] stub_q_reg;
    logic [N-1:0]    adj_q_reg;

    logic            stub_we, adj_we;
    logic [NW-1:0]   stub_ra, stub_wa, adj_ra, adj_wa;
    logic [2*SW-1:0] stub_wd;
    logic [N-1:0]    adj_wd;

    state_t            state_reg;
    logic              bt_en_reg;
    logic [7:0]        max_bt_reg;
    logic [TW-1:0]     total_reg;
    logic [rsm_pkg::REJ_W-1:0] rej_reg;
    logic [9:0]        node_reg;
    logic [SW-1:0]     stubs_reg;
    logic [RW-1:0]     r1_reg, r2_reg;
    logic [NW-1:0]     ea_reg, eb_reg, cnt_reg, idx_reg;
    logic [TW-1:0]     x_reg;
    logic [PW-1:0]     prefix_reg;
    logic              pend_reg, sel_reg;
    rsm_pkg::take_t    da_reg, db_reg;
    logic [1:0]        status_reg;
    logic              zero_a_reg;

    logic              push_ready;
    rsm_pkg::result_t  push_data;

    logic [SW-1:0]     q_rem, q_mat;
    logic [PW-1:0]     sum;
    logic [8:0]        limit;
    logic [TW-1:0]     old_tot;
    logic [TW:0]       load_sum;
    logic [NW-1:0]     tk_node, gb_node;
    rsm_pkg::take_t    tk_done, gb_done;

    assign q_rem   = stub_q_reg[2*SW-1:SW];
    assign q_mat   = stub_q_reg[SW-1:0];
    assign sum     = prefix_reg + PW'(q_rem);
    assign limit   = 9'd1 + (bt_en_reg ? {1'b0, max_bt_reg} : 9'd0);
    assign old_tot = (total_reg > TW'(q_rem)) ? (total_reg - TW'(q_rem)) : '0;
    assign load_sum = {1'b0, old_tot} + (TW+1)'(stubs_reg);
    assign tk_node = sel_reg ? eb_reg : ea_reg;
    assign gb_node = sel_reg ? ea_reg : eb_reg;
    assign gb_done = sel_reg ? da_reg : db_reg;

    assign tk_done.rem = (q_rem != '0);
    assign tk_done.mat = (q_mat != rsm_pkg::STUB_MAX);
    assign tk_done.tot = (total_reg != '0);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        stub_we = 1'b0;
        adj_we  = 1'b0;
        stub_wa = ea_reg;
        adj_wa  = ea_reg;
        stub_wd = '0;
        adj_wd  = '0;
        stub_ra = ea_reg;
        adj_ra  = ea_reg;
        case (state_reg)
            S_CLEAR:
            begin
                stub_we = 1'b1;
                adj_we  = 1'b1;
                stub_wa = cnt_reg;
                adj_wa  = cnt_reg;
            end
            S_LD_RD:
            begin
                stub_ra = node_reg[NW-1:0];
            end
            S_LD_WR:
            begin
                stub_we = 1'b1;
                adj_we  = 1'b1;
                stub_wa = node_reg[NW-1:0];
                adj_wa  = node_reg[NW-1:0];
                stub_wd = {stubs_reg, {SW{1'b0}}};
            end
            S_SCAN:
            begin
                stub_ra = cnt_reg;
            end
            S_TK_RD:
            begin
                stub_ra = tk_node;
            end
            S_TK_WR:
            begin
                stub_we = 1'b1;
                stub_wa = tk_node;
                stub_wd = {q_rem - SW'(tk_done.rem), q_mat + SW'(tk_done.mat)};
            end
            S_ADJ_RD:
            begin
                adj_ra = ea_reg;
            end
            S_ADJ_CHK:
            begin
                adj_we = (ea_reg != eb_reg) && !adj_q_reg[eb_reg];
                adj_wa = ea_reg;
                adj_wd = adj_q_reg | (N'(1) << eb_reg);
            end
            S_ADJ_RD2:
            begin
                adj_ra = eb_reg;
            end
            S_ADJ_WR2:
            begin
                adj_we = 1'b1;
                adj_wa = eb_reg;
                adj_wd = adj_q_reg | (N'(1) << ea_reg);
            end
            S_GB_RD:
            begin
                stub_ra = gb_node;
            end
            S_GB_WR:
            begin
                stub_we = 1'b1;
                stub_wa = gb_node;
                stub_wd = {q_rem + SW'(gb_done.rem), q_mat - SW'(gb_done.mat)};
            end
            default:
            begin
                stub_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        stub_q_reg <= stub_mem[stub_ra];
        adj_q_reg  <= adj_mem[adj_ra];
        if (stub_we)
        begin
            stub_mem[stub_wa] <= stub_wd;
        end
        if (adj_we)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bt_en_reg <= 1'b1;
            max_bt_reg <= 8'd80;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsm_pkg::REG_BT_EN:  bt_en_reg  <= cfg_data[0];
                rsm_pkg::REG_MAX_BT: max_bt_reg <= cfg_data;
                default:             bt_en_reg  <= bt_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            total_reg  <= '0;
            rej_reg    <= '0;
            pend_reg   <= 1'b0;
            sel_reg    <= 1'b0;
            zero_a_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == NW'(N - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        node_reg   <= s_axis_tdata[9:0];
                        stubs_reg  <= s_axis_tdata[19:10];
                        r1_reg     <= s_axis_tdata[35:20];
                        r2_reg     <= s_axis_tdata[51:36];
                        ea_reg     <= '0;
                        eb_reg     <= '0;
                        sel_reg    <= 1'b0;
                        zero_a_reg <= 1'b0;
                        if (s_axis_tuser == rsm_pkg::CMD_LOAD)
                        begin
                            status_reg <= rsm_pkg::ST_LOAD;
                            if (32'(s_axis_tdata[9:0]) < N)
                            begin
                                state_reg <= S_LD_RD;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else if (total_reg <= rsm_pkg::STOP_TOTAL
                                 || 9'(rej_reg) >= limit)
                        begin
                            status_reg <= rsm_pkg::ST_FINISH;
                            zero_a_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            zero_a_reg <= 1'b1;
                            state_reg  <= S_MUL;
                        end
                    end
                end
                S_LD_RD:
                begin
                    state_reg <= S_LD_WR;
                end
                S_LD_WR:
                begin
                    if (node_reg == '0)
                    begin
                        total_reg <= TW'(stubs_reg);
                        rej_reg   <= '0;
                    end
                    else if (load_sum[TW])
                    begin
                        total_reg <= rsm_pkg::TOTAL_MAX;
                    end
                    else
                    begin
                        total_reg <= load_sum[TW-1:0];
                    end
                    state_reg <= S_DONE;
                end
                S_MUL:
                begin
                    x_reg      <= TW'(((RW+TW)'(sel_reg ? r2_reg : r1_reg)
                                       * (RW+TW)'(total_reg)) >> RW);
                    prefix_reg <= '0;
                    cnt_reg    <= '0;
                    pend_reg   <= 1'b0;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    // address runs one ahead of the compare
                    cnt_reg  <= cnt_reg + 1'b1;
                    idx_reg  <= cnt_reg;
                    pend_reg <= 1'b1;
                    if (pend_reg)
                    begin
                        prefix_reg <= sum;
                        if (PW'(x_reg) < sum || idx_reg == NW'(N - 1))
                        begin
                            if (sel_reg)
                            begin
                                eb_reg <= idx_reg;
                            end
                            else
                            begin
                                ea_reg <= idx_reg;
                            end
                            state_reg <= S_TK_RD;
                        end
                    end
                end
                S_TK_RD:
                begin
                    state_reg <= S_TK_WR;
                end
                S_TK_WR:
                begin
                    if (tk_done.tot)
                    begin
                        total_reg <= total_reg - 1'b1;
                    end
                    if (sel_reg)
                    begin
                        db_reg    <= tk_done;
                        state_reg <= S_ADJ_RD;
                    end
                    else
                    begin
                        da_reg    <= tk_done;
                        sel_reg   <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_ADJ_RD:
                begin
                    state_reg <= S_ADJ_CHK;
                end
                S_ADJ_CHK:
                begin
                    sel_reg <= 1'b0;
                    if (ea_reg != eb_reg && !adj_q_reg[eb_reg])
                    begin
                        status_reg <= rsm_pkg::ST_EDGE;
                        state_reg  <= S_ADJ_RD2;
                    end
                    else
                    begin
                        status_reg <= rsm_pkg::ST_REJECT;
                        if (rej_reg != rsm_pkg::REJ_MAX)
                        begin
                            rej_reg <= rej_reg + 1'b1;
                        end
                        state_reg <= bt_en_reg ? S_GB_RD : S_DONE;
                    end
                end
                S_ADJ_RD2:
                begin
                    state_reg <= S_ADJ_WR2;
                end
                S_ADJ_WR2:
                begin
                    state_reg <= S_DONE;
                end
                S_GB_RD:
                begin
                    state_reg <= S_GB_WR;
                end
                S_GB_WR:
                begin
                    if (gb_done.tot)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    if (sel_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_GB_RD;
                    end
                end
                S_DONE:
                begin
                    if (push_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        push_data.stubs_left = total_reg;
        push_data.status     = status_reg;
        push_data.end_a      = zero_a_reg ? 10'(ea_reg) : node_reg;
        push_data.end_b      = 10'(eb_reg);
    end

    rsm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_valid    (state_reg == S_DONE),
        .push_data     (push_data),
        .push_ready    (push_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
